[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the comment stripper modules.
// CCS_ASSERT expects signals clk and rst_n in the using module, CCS_ASSERT_ALWAYS only clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define CCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ccs_pkg.sv]
// ---------------------------------------------------------------------------
// ccs_pkg
// Types and constants shared by the comment stripper modules.
// ---------------------------------------------------------------------------
package ccs_pkg;

  // Scanner modes.
  typedef enum logic [3:0] {
    MODE_NORMAL     = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_STR        = 4'd2,
    MODE_STR_ESC    = 4'd3,
    MODE_CHR        = 4'd4,
    MODE_CHR_ESC    = 4'd5,
    MODE_LINE       = 4'd6,
    MODE_LINE_BS    = 4'd7,
    MODE_BLOCK      = 4'd8,
    MODE_BLOCK_STAR = 4'd9
  } scan_mode_t;

  // Characters the scanner looks for.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Queue between scanner and output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // All results caused by one request. A run holds one result, or two when
  // two_res is set; byte0_vld is clear only for a bare end marker.
  typedef struct packed {
    logic       two_res;
    logic       byte0_vld;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       fin;
  } run_t;

endpackage

[hdl/ccs_if.sv]
// ---------------------------------------------------------------------------
// ccs_in_if / ccs_out_if
// Valid/ready channels for source bytes in and filtered bytes out.
// ---------------------------------------------------------------------------
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_run, output end_of_stream, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input last_of_run, input end_of_stream, output ready);
endinterface

[hdl/c_comment_stripper_top.sv]
// ---------------------------------------------------------------------------
// c_comment_stripper_top
// C comment removal filter: source bytes in, bytes without comments out.
// ---------------------------------------------------------------------------
// Usage:
// The in_ch channel takes one source byte per request, with end_of_input
// set on the final byte of a stream. The out_ch channel delivers the
// filtered bytes. Each request causes zero, one or two results; the last
// result of a request has last_of_run set, and the last result of the
// final request also has end_of_stream set. If the final request emits no
// byte, one bare end marker (byte_valid low, out_byte zero) is delivered.
// A result passes through the run queue and then the output register before
// it is presented on out_ch, and a second result of the same request follows
// it. The front takes one request per cycle while the queue is not full. The
// output register sends one result per cycle while the receiver is ready,
// so the four-entry run queue absorbs the second result of a request that
// yields two (a held slash followed by a non-comment byte).
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ch.ready drops only once the queue is full.
// Reset (rst_n low at a clock edge) returns the scanner to normal text and
// empties the queue and the output register.
// ---------------------------------------------------------------------------
module c_comment_stripper_top
  import ccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ccs_in_if.sink      in_ch,
  ccs_out_if.source   out_ch
);

  // Scanner to queue.
  logic push;
  run_t push_run;
  logic q_full;

  // Queue to output stage.
  logic head_vld;
  run_t head_run;
  logic pop;

  // Front: mode tracking and run building, one request per cycle while the queue is not full.
  ccs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_run (push_run)
  );

  // Queue decouples the scanner from stalls at the output.
  ccs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .head_vld (head_vld),
    .head_run (head_run),
    .pop      (pop)
  );

  // Back: splits runs into single results behind the output register.
  ccs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head_run (head_run),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[hdl/ccs_front.sv]
// ---------------------------------------------------------------------------
// ccs_front
// Scanner: accepts source bytes, tracks the comment/literal mode and builds
// one run of results per request that produces any or that ends the stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccs_front
  import ccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ccs_in_if.sink      in_ch,
  input  logic        q_full,
  output logic        push,
  output run_t        push_run
);

  typedef struct packed {
    scan_mode_t mode;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } step_t;

  scan_mode_t mode_r;
  scan_mode_t mode_nxt;
  step_t      st;
  logic       accept;

  // Mode after a byte seen in normal text (slash handled by the caller).
  function automatic scan_mode_t normal_mode(logic [7:0] b);
    scan_mode_t m;
    m = MODE_NORMAL;
    if (b == CH_DQ) begin
      m = MODE_STR;
    end else if (b == CH_SQ) begin
      m = MODE_CHR;
    end
    return m;
  endfunction

  function automatic step_t scan_step(scan_mode_t m, logic [7:0] b, logic fin);
    step_t s;
    s.mode = m;
    s.cnt  = 2'd0;
    s.b0   = 8'h00;
    s.b1   = 8'h00;
    case (m)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          s.mode = MODE_LINE;
        end else if (b == CH_STAR) begin
          s.mode = MODE_BLOCK;
        end else begin
          // Not a comment: the held slash goes out ahead of this byte.
          s.cnt  = 2'd2;
          s.b0   = CH_SLASH;
          s.b1   = b;
          s.mode = normal_mode(b);
        end
      end
      MODE_STR: begin
        s.cnt = 2'd1;
        s.b0  = b;
        if (b == CH_BSL) begin
          s.mode = MODE_STR_ESC;
        end else if (b == CH_DQ) begin
          s.mode = MODE_NORMAL;
        end
      end
      MODE_STR_ESC: begin
        s.cnt  = 2'd1;
        s.b0   = b;
        s.mode = MODE_STR;
      end
      MODE_CHR: begin
        s.cnt = 2'd1;
        s.b0  = b;
        if (b == CH_BSL) begin
          s.mode = MODE_CHR_ESC;
        end else if (b == CH_SQ) begin
          s.mode = MODE_NORMAL;
        end
      end
      MODE_CHR_ESC: begin
        s.cnt  = 2'd1;
        s.b0   = b;
        s.mode = MODE_CHR;
      end
      MODE_LINE: begin
        if (b == CH_NL) begin
          s.cnt  = 2'd1;
          s.b0   = CH_SPACE;
          s.mode = MODE_NORMAL;
        end else if (b == CH_BSL) begin
          s.mode = MODE_LINE_BS;
        end
      end
      MODE_LINE_BS: begin
        if (b == CH_NL) begin
          s.cnt  = 2'd1;
          s.b0   = CH_SPACE;
          s.mode = MODE_LINE;
        end else if (b != CH_BSL) begin
          s.mode = MODE_LINE;
        end
      end
      MODE_BLOCK: begin
        if (b == CH_STAR) begin
          s.mode = MODE_BLOCK_STAR;
        end
      end
      MODE_BLOCK_STAR: begin
        if (b == CH_SLASH) begin
          s.mode = MODE_NORMAL;
        end else if (b != CH_STAR) begin
          s.mode = MODE_BLOCK;
        end
      end
      default: begin
        // Normal text, and any unused mode code.
        if (b == CH_SLASH) begin
          s.mode = MODE_SLASH;
        end else begin
          s.cnt  = 2'd1;
          s.b0   = b;
          s.mode = normal_mode(b);
        end
      end
    endcase
    // At the end of the stream a slash still held is flushed.
    if (fin) begin
      if (s.mode == MODE_SLASH) begin
        if (s.cnt == 2'd0) begin
          s.cnt = 2'd1;
          s.b0  = CH_SLASH;
        end else begin
          s.cnt = 2'd2;
          s.b1  = CH_SLASH;
        end
      end
      s.mode = MODE_NORMAL;
    end
    return s;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign st          = scan_step(mode_r, in_ch.in_byte, in_ch.end_of_input);

  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      mode_nxt = st.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // A request that yields nothing and does not end the stream adds no run.
  assign push               = accept && ((st.cnt != 2'd0) || in_ch.end_of_input);
  assign push_run.two_res   = (st.cnt == 2'd2);
  assign push_run.byte0_vld = (st.cnt != 2'd0);
  assign push_run.byte0     = st.b0;
  assign push_run.byte1     = st.b1;
  assign push_run.fin       = in_ch.end_of_input;

  `CCS_ASSERT(a_fin_resets_mode, accept && in_ch.end_of_input |=> mode_r == MODE_NORMAL, "front: mode not normal after final byte")

endmodule

[hdl/ccs_queue.sv]
// ---------------------------------------------------------------------------
// ccs_queue
// Short FIFO of runs between the scanner and the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccs_queue
  import ccs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_run,
  output logic full,
  output logic head_vld,
  output run_t head_run,
  input  logic pop
);

  run_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_run = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_run;
    end
  end

  `CCS_ASSERT(a_no_push_full, full |-> !push, "queue: push while full")
  `CCS_ASSERT(a_cnt_range, cnt_r <= QCNT_W'(QDEPTH), "queue: count beyond depth")

endmodule

[hdl/ccs_back.sv]
// ---------------------------------------------------------------------------
// ccs_back
// Output stage: unpacks each run into results, one per cycle while the
// receiver is ready, through an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccs_back
  import ccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  run_t        head_run,
  output logic        pop,
  ccs_out_if.source   out_ch
);

  logic       ov_r, ov_nxt;
  logic       second_r, second_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bvld_r, bvld_nxt;
  logic       last_r, last_nxt;
  logic       eos_r, eos_nxt;
  logic       load;

  assign load = !ov_r || out_ch.ready;

  always_comb begin
    ov_nxt     = ov_r;
    second_nxt = second_r;
    byte_nxt   = byte_r;
    bvld_nxt   = bvld_r;
    last_nxt   = last_r;
    eos_nxt    = eos_r;
    pop        = 1'b0;
    if (load) begin
      ov_nxt = head_vld;
      if (head_vld) begin
        if (second_r) begin
          byte_nxt   = head_run.byte1;
          bvld_nxt   = 1'b1;
          last_nxt   = 1'b1;
          eos_nxt    = head_run.fin;
          second_nxt = 1'b0;
          pop        = 1'b1;
        end else if (head_run.two_res) begin
          byte_nxt   = head_run.byte0;
          bvld_nxt   = 1'b1;
          last_nxt   = 1'b0;
          eos_nxt    = 1'b0;
          second_nxt = 1'b1;
        end else begin
          byte_nxt = head_run.byte0;
          bvld_nxt = head_run.byte0_vld;
          last_nxt = 1'b1;
          eos_nxt  = head_run.fin;
          pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      second_r <= 1'b0;
    end else begin
      ov_r     <= ov_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bvld_r <= bvld_nxt;
    last_r <= last_nxt;
    eos_r  <= eos_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.byte_valid    = bvld_r;
  assign out_ch.last_of_run   = last_r;
  assign out_ch.end_of_stream = eos_r;

  `CCS_ASSERT(a_second_has_head, second_r |-> head_vld && head_run.two_res, "back: second half without run")
  `CCS_ASSERT(a_marker_ends_run, ov_r && !bvld_r |-> last_r && eos_r, "back: bare marker not closing stream")

endmodule
